>>> sv/bloom_filter_string_lookup_macros.svh
// assertion macros for the bloom filter string lookup checker
// no dependencies; included by files that hold concurrent assertions
`ifndef BLOOM_FILTER_STRING_LOOKUP_MACROS_SVH
`define BLOOM_FILTER_STRING_LOOKUP_MACROS_SVH

// same-cycle implication, disabled during reset
`define BFSL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define BFSL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/bfsl_pkg.sv
// shared types, constants and hash functions for the bloom filter string lookup
// no dependencies; imported by the top level and the checker
`default_nettype none

package bfsl_pkg;

    localparam int unsigned FILTER_BITS_DEFAULT = 1048576;
    localparam int unsigned HASH_W              = 32;
    localparam int unsigned BYTE_FIELD_W        = 8;
    localparam int unsigned ADDR_FIELD_W        = 17;
    localparam int unsigned OUT_DEPTH           = 16;   // power of two
    localparam int unsigned HASH_COUNT_W        = 2;
    localparam logic [1:0]  HASH_COUNT_RESET    = 2'd2;
    localparam logic [1:0]  HASH_COUNT_MAX      = 2'd2;

    localparam int unsigned SAX_SHL  = 5;
    localparam int unsigned SAX_SHR  = 2;
    localparam int unsigned SDBM_SHL_LO = 6;
    localparam int unsigned SDBM_SHL_HI = 16;

    typedef enum logic [1:0] {
        MODE_LOAD = 2'd0,
        MODE_KEY  = 2'd1,
        MODE_END  = 2'd2
    } mode_t;

    // an item that closes a key and produces one result
    function automatic logic produces_result(input logic [1:0] mode,
                                             input logic [BYTE_FIELD_W-1:0] c);
        logic res;
        case (mode_t'(mode))
            MODE_KEY: res = (c == '0);
            MODE_END: res = 1'b1;
            default:  res = 1'b0;
        endcase
        return res;
    endfunction

    function automatic logic [HASH_W-1:0] sax_step(input logic [HASH_W-1:0] h,
                                                   input logic [BYTE_FIELD_W-1:0] c);
        return h ^ ((h << SAX_SHL) + (h >> SAX_SHR) + HASH_W'(c));
    endfunction

    function automatic logic [HASH_W-1:0] sdbm_step(input logic [HASH_W-1:0] h,
                                                    input logic [BYTE_FIELD_W-1:0] c);
        return HASH_W'(c) + (h << SDBM_SHL_LO) + (h << SDBM_SHL_HI) - h;
    endfunction

endpackage

`default_nettype wire

>>> sv/bfsl_ram.sv
// generic ram: one write port, two read ports with registered read data
// no dependencies
`default_nettype none

module bfsl_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256,
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr_a,
    input  wire logic [ADDR_W-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]  rd_data_a,
    output logic      [WIDTH-1:0]  rd_data_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_a <= mem_reg[rd_addr_a];
        rd_data_b <= mem_reg[rd_addr_b];
    end

endmodule

`default_nettype wire

>>> sv/bloom_filter_string_lookup.sv
// Bloom filter lookup for byte-string keys. Takes one item per cycle while
// s_axis_tready is high: loads, key bytes and ends of key alike. An accepted
// end of key registers its hashes; four stages then reduce the SAX and SDBM
// hashes modulo FILTER_BITS (reciprocal multiply, back multiply, subtract, one
// correction), then both filter bytes are read together from a two-read-port
// RAM. Loads go down the same stages and write at the read stage, so reads
// and writes stay in item order. Results wait in a 16-deep FIFO; s_axis_tready
// drops only while 16 results are outstanding. There is no clearing pass: the
// filter must be loaded before it is queried. cfg_ready is always high.
// Depends on bfsl_pkg and bfsl_ram.
`default_nettype none

module bloom_filter_string_lookup
    import bfsl_pkg::*;
#(
    parameter int unsigned FILTER_BITS = FILTER_BITS_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [7:0] byte_value, [24:8] store_address
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] mode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [0] hit
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_data         // [1:0] hash_count
);

    localparam int unsigned STORE_BYTES = (FILTER_BITS + 7) / 8;
    localparam int unsigned ADDR_SPAN   = 2 ** ADDR_FIELD_W;
    localparam int unsigned MEM_DEPTH   = (STORE_BYTES < ADDR_SPAN) ? STORE_BYTES : ADDR_SPAN;
    localparam int unsigned BYTE_W      = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int unsigned IDX_W       = $clog2(FILTER_BITS);
    localparam int unsigned R_W         = IDX_W + 1;
    localparam logic [HASH_W-1:0] RECIP = HASH_W'((64'd1 << HASH_W) / 64'(FILTER_BITS));
    localparam logic [HASH_W-1:0] FBITS = HASH_W'(FILTER_BITS);
    localparam logic [R_W-1:0]    FBITS_R = R_W'(FILTER_BITS);
    localparam int unsigned PTR_W    = $clog2(OUT_DEPTH);
    localparam int unsigned CREDIT_W = $clog2(OUT_DEPTH + 1);
    localparam int unsigned LD_STAGES = 5;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] addr;
        logic [7:0]        data;
    } ld_t;

    // input decode
    logic                    in_acc;
    logic [BYTE_FIELD_W-1:0] in_byte;
    logic [ADDR_FIELD_W-1:0] in_addr;
    logic                    is_query;
    logic                    is_key;
    logic                    is_load;

    // hash accumulators
    logic [HASH_W-1:0] sax_reg, sax_next;
    logic [HASH_W-1:0] sdbm_reg, sdbm_next;
    logic [1:0]        hash_count_reg;
    logic [1:0]        n_eff;

    // query pipeline, lane 0 sax, lane 1 sdbm
    logic              q1_v_reg, q2_v_reg, q3_v_reg, q4_v_reg, q5_v_reg, q6_v_reg;
    logic [HASH_W-1:0] q1_h_reg   [2];
    logic [HASH_W-1:0] q2_h_reg   [2];
    logic [HASH_W-1:0] q2_quo_reg [2];
    logic [HASH_W-1:0] q3_h_reg   [2];
    logic [HASH_W-1:0] q3_qf_reg  [2];
    logic [R_W-1:0]    q4_r_reg   [2];
    logic [IDX_W-1:0]  q5_idx_reg [2];
    logic [2:0]        q6_off_reg [2];
    logic [HASH_W-1:0] quo_next   [2];
    logic [HASH_W-1:0] qf_next    [2];
    logic [R_W-1:0]    r_next     [2];
    logic [IDX_W-1:0]  idx_next   [2];

    ld_t ld_reg [LD_STAGES];
    ld_t ld_in;

    // memory
    logic [BYTE_W-1:0] rd_addr [2];
    logic [7:0]        rd_data [2];
    logic              hit;

    // result fifo and credits
    logic              fifo_reg [OUT_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CREDIT_W-1:0] fill_reg, fill_next;
    logic [CREDIT_W-1:0] credit_reg, credit_next;
    logic              pop;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (credit_reg < CREDIT_W'(OUT_DEPTH));

    always_comb begin
        in_acc   = s_axis_tvalid & s_axis_tready;
        in_byte  = s_axis_tdata[7:0];
        in_addr  = s_axis_tdata[24:8];
        is_query = in_acc & produces_result(s_axis_tuser, in_byte);
        is_key   = in_acc & (mode_t'(s_axis_tuser) == MODE_KEY) & (in_byte != '0);
        is_load  = in_acc & (mode_t'(s_axis_tuser) == MODE_LOAD);

        sax_next  = sax_reg;
        sdbm_next = sdbm_reg;
        if (is_key) begin
            sax_next  = sax_step(sax_reg, in_byte);
            sdbm_next = sdbm_step(sdbm_reg, in_byte);
        end else if (is_query) begin
            sax_next  = '0;
            sdbm_next = '0;
        end

        ld_in.valid = is_load & (32'(in_addr) < 32'(STORE_BYTES));
        ld_in.addr  = BYTE_W'(in_addr);
        ld_in.data  = in_byte;
    end

    // modulo reduction: quotient estimate is low by at most one
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            quo_next[i] = HASH_W'(({32'd0, q1_h_reg[i]} * {32'd0, RECIP}) >> HASH_W);
            qf_next[i]  = HASH_W'(q2_quo_reg[i] * FBITS);
            r_next[i]   = R_W'(q3_h_reg[i] - q3_qf_reg[i]);
            idx_next[i] = (q4_r_reg[i] >= FBITS_R) ? IDX_W'(q4_r_reg[i] - FBITS_R)
                                                   : IDX_W'(q4_r_reg[i]);
            rd_addr[i]  = BYTE_W'(q5_idx_reg[i] >> 3);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sax_reg        <= '0;
            sdbm_reg       <= '0;
            hash_count_reg <= HASH_COUNT_RESET;
            q1_v_reg       <= 1'b0;
            q2_v_reg       <= 1'b0;
            q3_v_reg       <= 1'b0;
            q4_v_reg       <= 1'b0;
            q5_v_reg       <= 1'b0;
            q6_v_reg       <= 1'b0;
            for (int s = 0; s < LD_STAGES; s++) begin
                ld_reg[s] <= '0;
            end
        end else begin
            sax_reg  <= sax_next;
            sdbm_reg <= sdbm_next;
            if (cfg_valid && cfg_ready) begin
                hash_count_reg <= cfg_data;
            end
            q1_v_reg <= is_query;
            q2_v_reg <= q1_v_reg;
            q3_v_reg <= q2_v_reg;
            q4_v_reg <= q3_v_reg;
            q5_v_reg <= q4_v_reg;
            q6_v_reg <= q5_v_reg;
            ld_reg[0] <= ld_in;
            for (int s = 1; s < LD_STAGES; s++) begin
                ld_reg[s] <= ld_reg[s-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        q1_h_reg[0] <= sax_reg;
        q1_h_reg[1] <= sdbm_reg;
        for (int i = 0; i < 2; i++) begin
            q2_h_reg[i]   <= q1_h_reg[i];
            q2_quo_reg[i] <= quo_next[i];
            q3_h_reg[i]   <= q2_h_reg[i];
            q3_qf_reg[i]  <= qf_next[i];
            q4_r_reg[i]   <= r_next[i];
            q5_idx_reg[i] <= idx_next[i];
            q6_off_reg[i] <= q5_idx_reg[i][2:0];
        end
    end

    // loads write at the same stage where queries read
    bfsl_ram #(
        .WIDTH (8),
        .DEPTH (MEM_DEPTH)
    ) u_store (
        .aclk      (aclk),
        .wr_en     (ld_reg[LD_STAGES-1].valid),
        .wr_addr   (ld_reg[LD_STAGES-1].addr),
        .wr_data   (ld_reg[LD_STAGES-1].data),
        .rd_addr_a (rd_addr[0]),
        .rd_addr_b (rd_addr[1]),
        .rd_data_a (rd_data[0]),
        .rd_data_b (rd_data[1])
    );

    always_comb begin
        n_eff = (hash_count_reg > HASH_COUNT_MAX) ? HASH_COUNT_MAX : hash_count_reg;
        hit   = ((n_eff < 2'd1) || rd_data[0][q6_off_reg[0]])
              && ((n_eff < 2'd2) || rd_data[1][q6_off_reg[1]]);
    end

    // result fifo
    assign pop           = m_axis_tvalid & m_axis_tready;
    assign m_axis_tvalid = (fill_reg != '0);
    assign m_axis_tdata  = {7'd0, fifo_reg[rd_ptr_reg]};

    always_comb begin
        fill_next   = fill_reg + CREDIT_W'(q6_v_reg) - CREDIT_W'(pop);
        credit_next = credit_reg + CREDIT_W'(is_query) - CREDIT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
            credit_reg <= '0;
        end else begin
            fill_reg   <= fill_next;
            credit_reg <= credit_next;
            if (q6_v_reg) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q6_v_reg) begin
            fifo_reg[wr_ptr_reg] <= hit;
        end
    end

endmodule

`default_nettype wire

>>> sv/bfsl_checker.sv
// port-level checker for the bloom filter string lookup, with its bind
// depends on bfsl_pkg and bloom_filter_string_lookup_macros.svh
`default_nettype none
`include "bloom_filter_string_lookup_macros.svh"

module bfsl_checker
    import bfsl_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [31:0] s_axis_tdata,
    input wire logic [1:0]  s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [7:0]  m_axis_tdata
);

    // results owed: ends of key accepted minus results taken
    logic [7:0] owed_reg, owed_next;
    logic       ask;
    logic       take;

    always_comb begin
        ask  = s_axis_tvalid & s_axis_tready
             & produces_result(s_axis_tuser, s_axis_tdata[7:0]);
        take = m_axis_tvalid & m_axis_tready;
        owed_next = owed_reg + 8'(ask) - 8'(take);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            owed_reg <= '0;
        end else begin
            owed_reg <= owed_next;
        end
    end

    `BFSL_ASSERT_IMP(a_no_spurious_result, m_axis_tvalid, owed_reg != 8'd0, "result without a pending key")
    `BFSL_ASSERT_IMP(a_ready_when_empty, owed_reg == 8'd0, s_axis_tready, "input stalled with no results owed")
    `BFSL_ASSERT_IMP(a_stall_when_full, owed_reg >= 8'(OUT_DEPTH), !s_axis_tready, "input taken beyond result space")
    `BFSL_ASSERT_IMP(a_pad_zero, m_axis_tvalid, m_axis_tdata[7:1] == 7'd0, "result padding not zero")
    `BFSL_ASSERT_NXT(a_valid_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")

endmodule

bind bloom_filter_string_lookup bfsl_checker u_bfsl_checker (.*);

`default_nettype wire

>>> sim/tb_bloom_filter_string_lookup.sv
// self-checking testbench for bloom_filter_string_lookup: directed table, then random keys
// under each hash count, with random idling on both streams; depends on bfsl_pkg and the rtl
module tb_bloom_filter_string_lookup;
    import bfsl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_PERIOD    = 8;
    localparam int          RESET_CYCLES  = 9;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          CYCLE_LIMIT   = 300000;
    localparam int          PHASE_ITEMS   = 130;
    localparam int          PHASES        = 8;
    localparam int          DIRECTED_ROWS = 25;
    localparam int          MAX_PRINTS    = 40;
    localparam int unsigned FILTER_BITS   = FILTER_BITS_DEFAULT;
    localparam int unsigned STORE_BYTES   = (FILTER_BITS + 7) / 8;
    localparam logic [31:0] SDBM_MULT     = 32'd65599;   // 2^16 + 2^6 - 1

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // expectation column of the directed table
    localparam logic [1:0] HIT_NO      = 2'd0;
    localparam logic [1:0] HIT_YES     = 2'd1;
    localparam logic [1:0] HIT_PREDICT = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  value;
        logic [16:0] addr;
        logic [1:0]  want;
    } stim_row_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // [7:0] byte_value, [24:8] store_address
    logic [1:0]  s_axis_tuser  = '0;   // [1:0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // [0] hit
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_data      = '0;   // [1:0] hash_count

    // lookup predictor state
    logic [31:0] sax_model      = '0;
    logic [31:0] sdbm_model     = '0;
    logic [1:0]  hash_count_cfg = HASH_COUNT_RESET;
    logic [7:0]  filter_copy    [0:STORE_BYTES-1];
    bit          filter_written [0:STORE_BYTES-1];

    logic        hit_expected [$];
    int          error_count   = 0;
    int          sent_items    = 0;
    int          stim_items    = 0;
    int          results_seen  = 0;
    int          cycle_count   = 0;
    int          ready_hold    = 0;
    int          ready_draw;

    stim_row_t   directed_rows [0:DIRECTED_ROWS-1];
    logic [1:0]  phase_hash_count [0:PHASES-1];

    bloom_filter_string_lookup u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL bloom_filter_string_lookup");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    function automatic logic [16:0] store_byte_of(input logic [31:0] h);
        return 17'((h % FILTER_BITS) >> 3);
    endfunction

    function automatic logic filter_bit(input logic [31:0] h);
        int unsigned idx;
        idx = h % FILTER_BITS;
        return filter_copy[idx >> 3][idx & 7];
    endfunction

    // advance the lookup state by one accepted item; reports whether a query closed
    function automatic void absorb_item(input logic [1:0] mode, input logic [7:0] value,
                                        input logic [16:0] addr,
                                        output logic closes, output logic hit);
        int tested;
        closes = 1'b0;
        hit    = 1'b0;
        case (mode)
            MODE_LOAD: begin
                if (addr < STORE_BYTES) begin
                    filter_copy[addr]    = value;
                    filter_written[addr] = 1'b1;
                end
            end
            MODE_KEY: begin
                if (value != 8'h00) begin
                    sax_model  = sax_model ^ ((sax_model << 5) + (sax_model >> 2)
                                              + 32'(value));
                    sdbm_model = sdbm_model * SDBM_MULT + 32'(value);
                end else begin
                    closes = 1'b1;
                end
            end
            MODE_END: closes = 1'b1;
            default: ;
        endcase
        if (closes) begin
            tested = (hash_count_cfg > HASH_COUNT_MAX) ? int'(HASH_COUNT_MAX)
                                                       : int'(hash_count_cfg);
            hit = 1'b1;
            if (tested >= 1 && !filter_bit(sax_model))
                hit = 1'b0;
            if (tested >= 2 && !filter_bit(sdbm_model))
                hit = 1'b0;
            sax_model  = '0;
            sdbm_model = '0;
        end
    endfunction

    // valid stays high across back-to-back items; it only drops for a gap
    task automatic push_item(input logic [1:0] mode, input logic [7:0] value,
                             input logic [16:0] addr, input logic [1:0] want);
        int   gap;
        logic closes;
        logic hit;
        gap = (((sent_items / 128) % 3) == 1) ? 0 : int'($urandom_range(0, 7));
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, addr, value};
        s_axis_tuser  <= mode;
        do @(posedge aclk); while (!s_axis_tready);
        absorb_item(mode, value, addr, closes, hit);
        if (closes)
            hit_expected.push_back((want == HIT_PREDICT) ? hit : want[0]);
        if (mode != MODE_UNUSED)
            stim_items++;
        sent_items++;
    endtask

    // a query may only read filter bytes that were loaded, so load them first
    task automatic send_item(input logic [1:0] mode, input logic [7:0] value,
                             input logic [16:0] addr, input logic [1:0] want);
        logic [16:0] tested_byte [0:1];
        if (mode == MODE_END || (mode == MODE_KEY && value == 8'h00)) begin
            tested_byte[0] = store_byte_of(sax_model);
            tested_byte[1] = store_byte_of(sdbm_model);
            for (int k = 0; k < 2; k++) begin
                if (!filter_written[tested_byte[k]])
                    push_item(MODE_LOAD,
                              ($urandom_range(0, 2) != 0) ? 8'hFF : 8'($urandom),
                              tested_byte[k], HIT_PREDICT);
            end
        end
        push_item(mode, value, addr, want);
    endtask

    task automatic wait_until_drained();
        s_axis_tvalid <= 1'b0;
        while (hit_expected.size() != 0) @(posedge aclk);
        // loads and key bytes leave no result but may still be in flight
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_hash_count(input logic [1:0] count);
        wait_until_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= count;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid      <= 1'b0;
        hash_count_cfg  = count;
    endtask

    function automatic logic [7:0] key_char();
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0, 1:    c = 8'h61 + 8'($urandom_range(0, 25));   // lower-case letters
            2:       c = 8'h2D + 8'($urandom_range(0, 12));   // - . / and digits
            default: c = 8'($urandom_range(1, 255));
        endcase
        return c;
    endfunction

    task automatic send_random_key();
        int len;
        len = ($urandom_range(0, 19) == 0) ? int'($urandom_range(13, 40))
                                           : int'($urandom_range(0, 12));
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 29) == 0)
                send_item(MODE_UNUSED, 8'($urandom), 17'($urandom), HIT_PREDICT);
            send_item(MODE_KEY, key_char(), 17'($urandom), HIT_PREDICT);
        end
        if ($urandom_range(0, 9) < 7)
            send_item(MODE_END, 8'($urandom), 17'($urandom), HIT_PREDICT);
        else
            send_item(MODE_KEY, 8'h00, 17'($urandom), HIT_PREDICT);
    endtask

    // result side: random stall after each item, with stretches of none
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            ready_hold    <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            if (hit_expected.size() == 0) begin
                report_mismatch($sformatf("result hit=%0b with no query pending",
                                          m_axis_tdata[0]));
            end else if (m_axis_tdata[0] !== hit_expected[0]) begin
                report_mismatch($sformatf("hit got %0b want %0b",
                                          m_axis_tdata[0], hit_expected[0]));
                void'(hit_expected.pop_front());
            end else begin
                void'(hit_expected.pop_front());
            end
            results_seen <= results_seen + 1;
            ready_draw = (((results_seen / 16) % 3) == 1) ? 0 : int'($urandom_range(0, 7));
            if (ready_draw == 0) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b0;
                ready_hold    <= ready_draw;
            end
        end else if (!m_axis_tready) begin
            if (ready_hold <= 1)
                m_axis_tready <= 1'b1;
            else
                ready_hold <= ready_hold - 1;
        end
    end

    initial begin
        int  phase_start;
        bit  held_off;
        int  pick;

        // empty key tests bit 0; "a" tests byte 12 bit 1; 0xff tests byte 31 bit 7
        directed_rows = '{
            '{MODE_LOAD,   8'h01, 17'h00000, HIT_PREDICT},
            '{MODE_LOAD,   8'hFF, 17'h0000C, HIT_PREDICT},
            '{MODE_LOAD,   8'h80, 17'h0001F, HIT_PREDICT},
            '{MODE_LOAD,   8'hA5, 17'h1FFFF, HIT_PREDICT},
            '{MODE_END,    8'h00, 17'h00000, HIT_YES},
            '{MODE_KEY,    8'h00, 17'h00000, HIT_YES},
            '{MODE_KEY,    8'h61, 17'h00000, HIT_PREDICT},
            '{MODE_END,    8'hFF, 17'h1FFFF, HIT_YES},
            '{MODE_KEY,    8'hFF, 17'h00000, HIT_PREDICT},
            '{MODE_KEY,    8'h00, 17'h00000, HIT_YES},
            '{MODE_UNUSED, 8'hFF, 17'h1FFFF, HIT_PREDICT},
            '{MODE_UNUSED, 8'h00, 17'h00000, HIT_PREDICT},
            '{MODE_LOAD,   8'hFE, 17'h00000, HIT_PREDICT},
            '{MODE_END,    8'h00, 17'h00000, HIT_NO},
            '{MODE_KEY,    8'h61, 17'h00000, HIT_PREDICT},
            '{MODE_UNUSED, 8'h5A, 17'h0AAAA, HIT_PREDICT},
            '{MODE_END,    8'h00, 17'h00000, HIT_YES},
            '{MODE_KEY,    8'h61, 17'h00000, HIT_PREDICT},
            '{MODE_KEY,    8'h62, 17'h00000, HIT_PREDICT},
            '{MODE_END,    8'h00, 17'h00000, HIT_PREDICT},
            '{MODE_KEY,    8'hFF, 17'h00000, HIT_PREDICT},
            '{MODE_KEY,    8'hFF, 17'h00000, HIT_PREDICT},
            '{MODE_KEY,    8'hFF, 17'h00000, HIT_PREDICT},
            '{MODE_KEY,    8'hFF, 17'h00000, HIT_PREDICT},
            '{MODE_KEY,    8'h00, 17'h00000, HIT_PREDICT}
        };
        phase_hash_count = '{2'd0, 2'd1, 2'd3, 2'd2, 2'd1, 2'd0, 2'd3, 2'd2};

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part runs with the reset hash count
        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_item(directed_rows[r].mode, directed_rows[r].value,
                      directed_rows[r].addr, directed_rows[r].want);

        for (int p = 0; p < PHASES; p++) begin
            set_hash_count(phase_hash_count[p]);
            phase_start = stim_items;
            held_off    = 1'b0;
            while (stim_items - phase_start < PHASE_ITEMS) begin
                pick = int'($urandom_range(0, 99));
                if (pick < 75)
                    send_random_key();
                else if (pick < 88)
                    send_item(MODE_LOAD, 8'($urandom), 17'($urandom), HIT_PREDICT);
                else
                    send_item(2'($urandom_range(0, 3)), 8'($urandom), 17'($urandom),
                              HIT_PREDICT);
                // hold the sender once mid-phase until the result side is empty
                if (p == 3 && !held_off && stim_items - phase_start >= PHASE_ITEMS / 2) begin
                    wait_until_drained();
                    held_off = 1'b1;
                end
            end
        end

        wait_until_drained();
        $display("run covered %0d stimulus items and %0d query results", stim_items,
                 results_seen);
        $display("hash counts 0 to 3, loads, keys closed by end item and by zero byte");
        if (error_count == 0 && hit_expected.size() == 0)
            $display("PASS bloom_filter_string_lookup");
        else
            $display("FAIL bloom_filter_string_lookup");
        $finish;
    end

endmodule
